/* sv/sda_pkg.sv */
// Shared types, constants and the power-of-ten table for the scaled decimal ALU.
package sda_pkg;

  localparam int WORD_W  = 128;
  localparam int POW_N   = 64;
  localparam int POW_MAX = 38;
  localparam int BIG_K   = 39;
  localparam int TEN     = 10;

  typedef logic [WORD_W-1:0] word_t;
  typedef word_t pow_tab_t [POW_N];

  // Operation codes.
  localparam logic [3:0] F_ADD     = 4'd0;
  localparam logic [3:0] F_SUB     = 4'd1;
  localparam logic [3:0] F_MUL     = 4'd2;
  localparam logic [3:0] F_DIV     = 4'd3;
  localparam logic [3:0] F_NEG     = 4'd4;
  localparam logic [3:0] F_ABS     = 4'd5;
  localparam logic [3:0] F_RESCALE = 4'd6;
  localparam logic [3:0] F_ROUND   = 4'd7;
  localparam logic [3:0] F_CMP     = 4'd8;

  // Rounding modes.
  localparam logic [2:0] RM_HALF_UP   = 3'd0;
  localparam logic [2:0] RM_HALF_DOWN = 3'd1;
  localparam logic [2:0] RM_HALF_EVEN = 3'd2;
  localparam logic [2:0] RM_CEILING   = 3'd3;
  localparam logic [2:0] RM_FLOOR     = 3'd4;

  function automatic pow_tab_t build_pow10();
    pow_tab_t t;
    word_t    p;
    p = word_t'(1);
    for (int i = 0; i < POW_N; i++) begin
      t[i] = (i <= POW_MAX) ? p : '0;
      p = p * word_t'(TEN);
    end
    return t;
  endfunction

  localparam pow_tab_t POW10 = build_pow10();

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_MUL_INIT,
    OP_MUL_STEP,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_ROUND,
    OP_FIXSIGN,
    OP_FINISH
  } dp_op_t;

  // Which scale difference selects the power of ten.
  typedef enum logic [2:0] {
    K_SA_SB,
    K_SB_SA,
    K_NEED,
    K_TS_SA,
    K_SA_TS,
    K_ONE,
    K_EXTRA
  } ksel_t;

  typedef struct packed {
    dp_op_t op;
    ksel_t  ksel;
    logic   dst_b;
    logic   src_b;
    logic   sc_dec;
  } dp_cmd_t;

  typedef struct packed {
    logic [3:0] func;
    logic       sa_gt_sb;
    logic       sb_gt_sa;
    logic       b_zero;
    logic       need_ok;
    logic       ts_ge_sa;
    logic       ts_eq_sa;
    logic       sc_over;
    logic       last;
    logic       big;
  } dp_stat_t;

endpackage

/* sv/sda_dp.sv */
// Datapath of the scaled decimal ALU: operand registers, shift-add multiplier,
// restoring divider, rounding and result registers.
module sda_dp #(
  parameter int MAX_SCALE     = 38,
  parameter int MAX_PRECISION = 38
) (
  input  logic              clk,
  input  sda_pkg::dp_cmd_t  cmd,
  output sda_pkg::dp_stat_t stat,
  input  logic [3:0]        func,
  input  sda_pkg::word_t    a_val,
  input  logic [5:0]        a_scale,
  input  logic [5:0]        a_precision,
  input  sda_pkg::word_t    b_val,
  input  logic [5:0]        b_scale,
  input  logic [5:0]        b_precision,
  input  logic [5:0]        tgt_scale,
  input  logic [5:0]        target_precision,
  input  logic [2:0]        round_mode,
  output sda_pkg::word_t    res_val,
  output logic [5:0]        res_scale,
  output logic [5:0]        res_prec,
  output logic [1:0]        res_order
);
  import sda_pkg::*;

  localparam logic [5:0] MAX_S = 6'(MAX_SCALE);
  localparam logic [5:0] MAX_P = 6'(MAX_PRECISION);
  localparam logic [5:0] BIG_K6 = 6'(BIG_K);

  function automatic logic [5:0] clamp_w(input logic [5:0] v, input logic [5:0] m);
    return (v > m) ? m : v;
  endfunction

  function automatic word_t mag_f(input word_t v);
    return v[WORD_W-1] ? -v : v;
  endfunction

  logic [3:0] func_r;
  word_t      va, vb, n, rr, d;
  logic [5:0] sa, sb, ts, k, pr;
  logic [2:0] mode;
  logic [6:0] sc, cnt;
  logic       rneg, big, fast, dst_b;

  logic [5:0] a_sc, b_sc, t_sc, a_pc, b_pc, t_pc, max_s, max_p;
  logic [6:0] pr_inc, pr_sum, need;
  logic [6:0] load_sc;
  logic [5:0] load_pr;
  logic       b_zero_in;
  logic [5:0] k_next;
  word_t      pow_k, half, mag_a, mag_b, prod_next, fin_val;
  logic [128:0] t_gen, diff_gen;
  logic       ge_gen;
  word_t      n_gen, rr_gen, n_fast;
  logic [3:0] r_fast;
  logic       inc_raw, inc;
  logic [1:0] fin_ord;

  // Clamp and decode the incoming request.
  always_comb begin
    a_sc = clamp_w(a_scale, MAX_S);
    b_sc = clamp_w(b_scale, MAX_S);
    t_sc = clamp_w(tgt_scale, MAX_S);
    a_pc = clamp_w(a_precision, MAX_P);
    b_pc = clamp_w(b_precision, MAX_P);
    t_pc = clamp_w(target_precision, MAX_P);
    max_s = (a_sc > b_sc) ? a_sc : b_sc;
    max_p = (a_pc > b_pc) ? a_pc : b_pc;
    pr_inc = {1'b0, max_p} + 7'd1;
    pr_sum = {1'b0, a_pc} + {1'b0, b_pc};
    b_zero_in = (b_val == '0);
    load_sc = '0;
    load_pr = '0;
    unique case (func) inside
      F_ADD, F_SUB: begin
        load_sc = {1'b0, max_s};
        load_pr = (pr_inc > {1'b0, MAX_P}) ? MAX_P : pr_inc[5:0];
      end
      F_MUL: begin
        load_sc = {1'b0, a_sc} + {1'b0, b_sc};
        load_pr = (pr_sum > {1'b0, MAX_P}) ? MAX_P : pr_sum[5:0];
      end
      F_DIV: begin
        load_sc = b_zero_in ? {1'b0, a_sc} : {1'b0, t_sc};
        load_pr = a_pc;
      end
      F_NEG, F_ABS: begin
        load_sc = {1'b0, a_sc};
        load_pr = a_pc;
      end
      F_RESCALE: begin
        load_sc = {1'b0, t_sc};
        load_pr = t_pc;
      end
      F_ROUND: begin
        load_sc = (t_sc >= a_sc) ? {1'b0, a_sc} : {1'b0, t_sc};
        load_pr = a_pc;
      end
      default: begin
        load_sc = '0;
        load_pr = '0;
      end
    endcase
  end

  // The divide scales the dividend by ten to the (sb + 2*ts + 1 - sa).
  assign need = {1'b0, sb} + {ts, 1'b0} + 7'd1;

  always_comb begin
    unique case (cmd.ksel)
      K_SA_SB: k_next = sa - sb;
      K_SB_SA: k_next = sb - sa;
      K_NEED:  k_next = 6'(need - {1'b0, sa});
      K_TS_SA: k_next = ts - sa;
      K_SA_TS: k_next = sa - ts;
      K_ONE:   k_next = 6'd1;
      K_EXTRA: k_next = ts + 6'd1;
      default: k_next = k;
    endcase
  end

  assign pow_k = POW10[k_next];
  assign half  = POW10[k] >> 1;
  assign mag_a = mag_f(va);
  assign mag_b = mag_f(vb);

  assign prod_next = n + (rr[0] ? d : '0);

  // One bit of restoring division against the full divisor.
  always_comb begin
    t_gen    = {rr, n[WORD_W-1]};
    diff_gen = t_gen - {1'b0, d};
    ge_gen   = (t_gen >= {1'b0, d});
    rr_gen   = ge_gen ? diff_gen[WORD_W-1:0] : t_gen[WORD_W-1:0];
    n_gen    = {n[WORD_W-2:0], ge_gen};
  end

  // Dividing by ten keeps the remainder in four bits, so eight bits fit a cycle.
  always_comb begin
    logic [4:0] r5;
    logic       g;
    r_fast = rr[3:0];
    n_fast = n;
    for (int i = 0; i < 8; i++) begin
      r5 = {r_fast, n_fast[WORD_W-1]};
      g = (r5 >= 5'(TEN));
      n_fast = {n_fast[WORD_W-2:0], g};
      r_fast = g ? 4'(r5 - 5'(TEN)) : r5[3:0];
    end
  end

  always_comb begin
    case (mode)
      RM_HALF_UP:   inc_raw = !big && (rr >= half);
      RM_HALF_DOWN: inc_raw = !big && (rr > half);
      RM_HALF_EVEN: inc_raw = !big && ((rr > half) || ((rr == half) && n[0]));
      RM_CEILING:   inc_raw = !rneg;
      RM_FLOOR:     inc_raw = rneg;
      default:      inc_raw = 1'b0;
    endcase
    inc = (rr != '0) && inc_raw;
  end

  always_comb begin
    unique case (func_r) inside
      F_ADD:                      fin_val = va + vb;
      F_SUB:                      fin_val = va - vb;
      F_MUL, F_RESCALE, F_ROUND:  fin_val = va;
      F_DIV:                      fin_val = (vb == '0) ? '0 : va;
      F_NEG:                      fin_val = -va;
      F_ABS:                      fin_val = mag_a;
      default:                    fin_val = '0;
    endcase
    if (func_r != F_CMP) begin
      fin_ord = 2'b00;
    end else if ($signed(va) < $signed(vb)) begin
      fin_ord = 2'b11;
    end else if ($signed(vb) < $signed(va)) begin
      fin_ord = 2'b01;
    end else begin
      fin_ord = 2'b00;
    end
  end

  always_comb begin
    stat.func     = func_r;
    stat.sa_gt_sb = (sa > sb);
    stat.sb_gt_sa = (sb > sa);
    stat.b_zero   = (vb == '0);
    stat.need_ok  = ({1'b0, sa} < need) && ((need - {1'b0, sa}) <= {1'b0, MAX_S});
    stat.ts_ge_sa = (ts >= sa);
    stat.ts_eq_sa = (ts == sa);
    stat.sc_over  = (sc > {1'b0, MAX_S});
    stat.last     = fast ? (cnt == 7'd15) : (cnt == 7'd127);
    stat.big      = big;
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD: begin
        func_r <= func;
        va     <= a_val;
        vb     <= b_val;
        sa     <= a_sc;
        sb     <= b_sc;
        ts     <= t_sc;
        mode   <= round_mode;
        sc     <= load_sc;
        pr     <= load_pr;
      end
      OP_MUL_INIT: begin
        k     <= k_next;
        d     <= cmd.dst_b ? vb : va;
        rr    <= cmd.src_b ? vb : pow_k;
        n     <= '0;
        cnt   <= '0;
        fast  <= 1'b0;
        dst_b <= cmd.dst_b;
      end
      OP_MUL_STEP: begin
        n   <= prod_next;
        d   <= d << 1;
        rr  <= rr >> 1;
        cnt <= cnt + 7'd1;
        if (cnt == 7'd127) begin
          if (dst_b) begin
            vb <= prod_next;
          end else begin
            va <= prod_next;
          end
        end
      end
      OP_DIV_INIT: begin
        k    <= k_next;
        big  <= !cmd.src_b && (k_next >= BIG_K6);
        fast <= !cmd.src_b && (k_next == 6'd1);
        rneg <= va[WORD_W-1] ^ (cmd.src_b & vb[WORD_W-1]);
        d    <= cmd.src_b ? mag_b : pow_k;
        cnt  <= '0;
        if (!cmd.src_b && (k_next >= BIG_K6)) begin
          n  <= '0;
          rr <= mag_a;
        end else begin
          n  <= mag_a;
          rr <= '0;
        end
      end
      OP_DIV_STEP: begin
        cnt <= cnt + 7'd1;
        if (fast) begin
          n  <= n_fast;
          rr <= {{(WORD_W-4){1'b0}}, r_fast};
        end else begin
          n  <= n_gen;
          rr <= rr_gen;
        end
      end
      OP_ROUND: begin
        n <= n + {{(WORD_W-1){1'b0}}, inc};
      end
      OP_FIXSIGN: begin
        va <= rneg ? -n : n;
        if (cmd.sc_dec) begin
          sc <= sc - 7'd1;
        end
      end
      OP_FINISH: begin
        res_val   <= fin_val;
        res_scale <= sc[5:0];
        res_prec  <= pr;
        res_order <= fin_ord;
      end
      default: begin
      end
    endcase
  end

endmodule

/* sv/sda_ctrl.sv */
// Controller of the scaled decimal ALU: sequences the datapath for each operation.
module sda_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  output logic              res_valid,
  input  logic              res_ready,
  output sda_pkg::dp_cmd_t  cmd,
  input  sda_pkg::dp_stat_t stat
);
  import sda_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_MUL,
    S_MCHK,
    S_SDIV,
    S_SROUND,
    S_DIV,
    S_ROUND,
    S_FIX,
    S_FINISH
  } state_t;

  state_t state, state_next, after_mul, after_mul_next, after_fix, after_fix_next;
  logic   rounding, rounding_next, res_valid_next;

  assign req_ready = (state == S_IDLE);

  always_comb begin
    cmd            = '{op: OP_NOP, ksel: K_ONE, dst_b: 1'b0, src_b: 1'b0, sc_dec: 1'b0};
    state_next     = state;
    after_mul_next = after_mul;
    after_fix_next = after_fix;
    rounding_next  = rounding;
    res_valid_next = res_valid && !res_ready;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.op     = OP_LOAD;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (stat.func) inside
          F_ADD, F_SUB, F_CMP: begin
            after_mul_next = S_FINISH;
            if (stat.sa_gt_sb) begin
              cmd.op     = OP_MUL_INIT;
              cmd.ksel   = K_SA_SB;
              cmd.dst_b  = 1'b1;
              state_next = S_MUL;
            end else if (stat.sb_gt_sa) begin
              cmd.op     = OP_MUL_INIT;
              cmd.ksel   = K_SB_SA;
              state_next = S_MUL;
            end else begin
              state_next = S_FINISH;
            end
          end
          F_MUL: begin
            cmd.op         = OP_MUL_INIT;
            cmd.src_b      = 1'b1;
            after_mul_next = S_MCHK;
            state_next     = S_MUL;
          end
          F_DIV: begin
            if (stat.b_zero) begin
              state_next = S_FINISH;
            end else if (stat.need_ok) begin
              cmd.op         = OP_MUL_INIT;
              cmd.ksel       = K_NEED;
              after_mul_next = S_SDIV;
              state_next     = S_MUL;
            end else begin
              state_next = S_SDIV;
            end
          end
          F_RESCALE, F_ROUND: begin
            if (((stat.func == F_ROUND) && stat.ts_ge_sa) || stat.ts_eq_sa) begin
              state_next = S_FINISH;
            end else if (stat.ts_ge_sa) begin
              cmd.op         = OP_MUL_INIT;
              cmd.ksel       = K_TS_SA;
              after_mul_next = S_FINISH;
              state_next     = S_MUL;
            end else begin
              cmd.op         = OP_DIV_INIT;
              cmd.ksel       = K_SA_TS;
              rounding_next  = 1'b1;
              after_fix_next = S_FINISH;
              state_next     = S_DIV;
            end
          end
          default: begin
            state_next = S_FINISH;
          end
        endcase
      end
      S_MUL: begin
        cmd.op = OP_MUL_STEP;
        if (stat.last) begin
          state_next = after_mul;
        end
      end
      S_MCHK: begin
        // Excess product scale is dropped one rounded digit per pass.
        if (stat.sc_over) begin
          cmd.op         = OP_DIV_INIT;
          cmd.ksel       = K_ONE;
          rounding_next  = 1'b1;
          after_fix_next = S_MCHK;
          state_next     = S_DIV;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_SDIV: begin
        cmd.op         = OP_DIV_INIT;
        cmd.src_b      = 1'b1;
        rounding_next  = 1'b0;
        after_fix_next = S_SROUND;
        state_next     = S_DIV;
      end
      S_SROUND: begin
        cmd.op         = OP_DIV_INIT;
        cmd.ksel       = K_EXTRA;
        rounding_next  = 1'b1;
        after_fix_next = S_FINISH;
        state_next     = S_DIV;
      end
      S_DIV: begin
        if (stat.big) begin
          state_next = S_ROUND;
        end else begin
          cmd.op = OP_DIV_STEP;
          if (stat.last) begin
            state_next = rounding ? S_ROUND : S_FIX;
          end
        end
      end
      S_ROUND: begin
        cmd.op     = OP_ROUND;
        state_next = S_FIX;
      end
      S_FIX: begin
        cmd.op     = OP_FIXSIGN;
        cmd.sc_dec = (after_fix == S_MCHK);
        state_next = after_fix;
      end
      S_FINISH: begin
        if (!res_valid || res_ready) begin
          cmd.op         = OP_FINISH;
          res_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      after_mul <= S_FINISH;
      after_fix <= S_FINISH;
      rounding  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      after_mul <= after_mul_next;
      after_fix <= after_fix_next;
      rounding  <= rounding_next;
      res_valid <= res_valid_next;
    end
  end

endmodule

/* sv/scaled_decimal_alu.sv */
// Scaled decimal ALU on 128-bit two's complement values with scale and precision.
// One request at a time is taken while req_ready is high; its single result is held on the
// result ports until taken, and the next request may enter while it waits. A request that
// needs no iteration (negate, abs, add/subtract/compare at equal scales, rescale or round
// with nothing to change, zero-divisor divide, unknown operations) passes only through the
// acceptance, dispatch and finish states, and res_valid rises as finish completes.
// Every multiply by a power of ten or by the other operand runs the shift-add multiplier at
// one bit per cycle. Rounding away several digits runs the restoring divider at one bit per
// cycle, then a round step and a sign fix; dropping a single digit uses its divide-by-ten
// mode at eight bits per cycle instead. A multiply drops each excess scale digit in turn
// after the product, and a divide scales the dividend up when needed, runs the signed
// divide, then rounds. A result still waiting to be taken holds the finish step.
module scaled_decimal_alu #(
  parameter int MAX_SCALE     = 38,
  parameter int MAX_PRECISION = 38
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  logic [3:0]         func,
  input  logic signed [63:0] a_hi,
  input  logic [63:0]        a_lo,
  input  logic [5:0]         a_scale,
  input  logic [5:0]         a_precision,
  input  logic signed [63:0] b_hi,
  input  logic [63:0]        b_lo,
  input  logic [5:0]         b_scale,
  input  logic [5:0]         b_precision,
  input  logic [5:0]         tgt_scale,
  input  logic [5:0]         target_precision,
  input  logic [2:0]         round_mode,
  output logic               res_valid,
  input  logic               res_ready,
  output logic signed [63:0] result_hi,
  output logic [63:0]        result_lo,
  output logic [5:0]         res_scale,
  output logic [5:0]         res_precision,
  output logic signed [1:0]  order
);
  import sda_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;
  word_t    a_val, b_val, res_val;
  logic [1:0] res_order;

  assign a_val = {a_hi, a_lo};
  assign b_val = {b_hi, b_lo};
  assign result_hi = res_val[127:64];
  assign result_lo = res_val[63:0];
  assign order = res_order;

  sda_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  sda_dp #(
    .MAX_SCALE     (MAX_SCALE),
    .MAX_PRECISION (MAX_PRECISION)
  ) u_dp (
    .clk              (clk),
    .cmd              (cmd),
    .stat             (stat),
    .func             (func),
    .a_val            (a_val),
    .a_scale          (a_scale),
    .a_precision      (a_precision),
    .b_val            (b_val),
    .b_scale          (b_scale),
    .b_precision      (b_precision),
    .tgt_scale        (tgt_scale),
    .target_precision (target_precision),
    .round_mode       (round_mode),
    .res_val          (res_val),
    .res_scale        (res_scale),
    .res_prec         (res_precision),
    .res_order        (res_order)
  );

endmodule
